// ===== src/pcsc_pkg.sv =====
package pcsc_pkg;

    // Idle ticks between periodic continuity samples.
    localparam logic [9:0] SAMPLE_PERIOD_TICKS = 10'd1000;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_ARM    = 3'd1,
        ACT_DISARM = 3'd2,
        ACT_FIRE   = 3'd3,
        ACT_TEST   = 3'd4,
        ACT_TICK   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        REF_NONE          = 3'd0,
        REF_ALREADY_FIRED = 3'd1,
        REF_SWITCH_OPEN   = 3'd2,
        REF_NO_CONTINUITY = 3'd3,
        REF_NOT_ARMED     = 3'd4,
        REF_ARMED         = 3'd5
    } refusal_t;

    typedef enum logic [2:0] {
        CFG_FIRE_DURATION = 3'd0,
        CFG_DIVIDER_RATIO = 3'd1,
        CFG_CONT_MIN      = 3'd2,
        CFG_ARM_SENSE_EN  = 3'd3,
        CFG_CONT_EN       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] fire_duration_ms;
        logic [11:0] divider_ratio_q8;
        logic [15:0] continuity_min_mv;
        logic        arm_sense_enabled;
        logic        continuity_enabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  fire_reason;
        logic        latch_already_fired;
        logic [11:0] sense_mv;
        logic        switch_closed;
        logic [2:0]  action;
    } item_t;

    typedef struct packed {
        logic        pulse_ended;
        logic        latch_write;
        logic [7:0]  recorded_reason;
        logic [15:0] fires_done;
        logic [15:0] match_mv;
        logic        continuity_good;
        logic        has_fired;
        logic        is_armed;
        logic        gate;
        logic [2:0]  refusal;
        logic        accepted;
    } result_t;

endpackage

// ===== src/pcsc_cfg_regs.sv =====
module pcsc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output pcsc_pkg::cfg_t     cfg
);

    pcsc_pkg::cfg_t cfg_reg;
    pcsc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pcsc_pkg::CFG_FIRE_DURATION: cfg_next.fire_duration_ms  = cfg_wdata;
                pcsc_pkg::CFG_DIVIDER_RATIO: cfg_next.divider_ratio_q8  = cfg_wdata[11:0];
                pcsc_pkg::CFG_CONT_MIN:      cfg_next.continuity_min_mv = cfg_wdata;
                pcsc_pkg::CFG_ARM_SENSE_EN:  cfg_next.arm_sense_enabled = cfg_wdata[0];
                pcsc_pkg::CFG_CONT_EN:       cfg_next.continuity_enabled = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fire_duration_ms   <= 16'd1000;
            cfg_reg.divider_ratio_q8   <= 12'd256;
            cfg_reg.continuity_min_mv  <= 16'd500;
            cfg_reg.arm_sense_enabled  <= 1'b1;
            cfg_reg.continuity_enabled <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pcsc_core.sv =====
module pcsc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  pcsc_pkg::item_t     item,
    input  pcsc_pkg::cfg_t      cfg,
    output pcsc_pkg::result_t   result
);

    logic        armed_reg, armed_next;
    logic        firing_reg, firing_next;
    logic        fired_reg, fired_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [9:0]  period_reg, period_next;
    logic        cont_ok_reg, cont_ok_next;
    logic [15:0] cont_mv_reg, cont_mv_next;
    logic [15:0] fire_count_reg, fire_count_next;
    logic [7:0]  reason_reg, reason_next;

    logic [23:0] product;
    logic [15:0] cand_mv;
    logic        cand_ok;
    logic [9:0]  period_inc;
    logic [15:0] elapsed_inc;

    // Divider scaling: 12-bit reading times Q4.8 ratio, fraction dropped.
    assign product = {12'd0, item.sense_mv} * {12'd0, cfg.divider_ratio_q8};
    assign cand_mv = product[23:8];
    assign cand_ok = (cand_mv >= cfg.continuity_min_mv);
    assign period_inc  = period_reg + 10'd1;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    always_comb
    begin
        logic       do_sample;
        logic       sample_firing;
        logic [2:0] refusal;
        logic       accepted;
        logic       latch_wr;
        logic       ended;

        armed_next      = armed_reg;
        firing_next     = firing_reg;
        fired_next      = fired_reg;
        elapsed_next    = elapsed_reg;
        period_next     = period_reg;
        fire_count_next = fire_count_reg;
        reason_next     = reason_reg;
        do_sample       = 1'b0;
        sample_firing   = firing_reg;
        refusal         = pcsc_pkg::REF_NONE;
        accepted        = 1'b1;
        latch_wr        = 1'b0;
        ended           = 1'b0;

        unique case (item.action)
            pcsc_pkg::ACT_INIT:
            begin
                armed_next    = 1'b0;
                firing_next   = 1'b0;
                fired_next    = item.latch_already_fired;
                do_sample     = 1'b1;
                sample_firing = 1'b0;
            end
            pcsc_pkg::ACT_ARM:
            begin
                if (fired_reg)
                    refusal = pcsc_pkg::REF_ALREADY_FIRED;
                else if (cfg.arm_sense_enabled && !item.switch_closed)
                    refusal = pcsc_pkg::REF_SWITCH_OPEN;
                else
                    do_sample = 1'b1;
            end
            pcsc_pkg::ACT_DISARM:
            begin
                armed_next  = 1'b0;
                firing_next = 1'b0;
            end
            pcsc_pkg::ACT_FIRE:
            begin
                if (!armed_reg)
                    refusal = pcsc_pkg::REF_NOT_ARMED;
                else if (fired_reg)
                    refusal = pcsc_pkg::REF_ALREADY_FIRED;
                else
                begin
                    fired_next   = 1'b1;
                    reason_next  = item.fire_reason;
                    latch_wr     = 1'b1;
                    firing_next  = 1'b1;
                    elapsed_next = 16'd0;
                    if (fire_count_reg != 16'hFFFF)
                        fire_count_next = fire_count_reg + 16'd1;
                end
            end
            pcsc_pkg::ACT_TEST:
            begin
                if (armed_reg)
                    refusal = pcsc_pkg::REF_ARMED;
                else
                begin
                    firing_next  = 1'b1;
                    elapsed_next = 16'd0;
                end
            end
            pcsc_pkg::ACT_TICK:
            begin
                if (firing_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= cfg.fire_duration_ms)
                    begin
                        firing_next = 1'b0;
                        ended       = 1'b1;
                    end
                end
                else if (period_inc >= pcsc_pkg::SAMPLE_PERIOD_TICKS)
                begin
                    period_next = 10'd0;
                    do_sample   = 1'b1;
                end
                else
                begin
                    period_next = period_inc;
                end
            end
            default:
            begin
                accepted = 1'b0;
            end
        endcase

        // Continuity sample: disabled forces zero, a running pulse holds the
        // last reading.
        cont_mv_next = cont_mv_reg;
        cont_ok_next = cont_ok_reg;
        if (do_sample)
        begin
            if (!cfg.continuity_enabled)
            begin
                cont_mv_next = 16'd0;
                cont_ok_next = 1'b0;
            end
            else if (!sample_firing)
            begin
                cont_mv_next = cand_mv;
                cont_ok_next = cand_ok;
            end
        end

        // Arm completes only once the fresh continuity result is known.
        if (item.action == pcsc_pkg::ACT_ARM && do_sample)
        begin
            if (cfg.continuity_enabled && !cont_ok_next)
                refusal = pcsc_pkg::REF_NO_CONTINUITY;
            else
                armed_next = 1'b1;
        end

        if (refusal != pcsc_pkg::REF_NONE)
            accepted = 1'b0;

        result.accepted        = accepted;
        result.refusal         = refusal;
        result.gate            = firing_next;
        result.is_armed        = armed_next;
        result.has_fired       = fired_next;
        result.continuity_good = cont_ok_next;
        result.match_mv        = cont_mv_next;
        result.fires_done      = fire_count_next;
        result.recorded_reason = reason_next;
        result.latch_write     = latch_wr;
        result.pulse_ended     = ended;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            firing_reg     <= 1'b0;
            fired_reg      <= 1'b0;
            elapsed_reg    <= 16'd0;
            period_reg     <= 10'd0;
            cont_ok_reg    <= 1'b0;
            cont_mv_reg    <= 16'd0;
            fire_count_reg <= 16'd0;
            reason_reg     <= 8'd0;
        end
        else if (step)
        begin
            armed_reg      <= armed_next;
            firing_reg     <= firing_next;
            fired_reg      <= fired_next;
            elapsed_reg    <= elapsed_next;
            period_reg     <= period_next;
            cont_ok_reg    <= cont_ok_next;
            cont_mv_reg    <= cont_mv_next;
            fire_count_reg <= fire_count_next;
            reason_reg     <= reason_next;
        end
    end

endmodule

// ===== src/pyro_channel_safety_controller.sv =====
// Channel   | Signals                                  | Direction | Content
// ----------+------------------------------------------+-----------+------------------------
// command   | s_tvalid s_tready s_tdata s_tuser        | in        | one command or tick
// result    | m_tvalid m_tready m_tdata                | out       | one status beat per cmd
// config    | cfg_we cfg_index cfg_wdata               | in        | register writes
//
// One beat is accepted per cycle when the result side keeps up; an accepted
// command waits in the input register and its result is then held in the
// result register. The channel state is updated in the same edge that loads
// the result register, so each command sees everything earlier ones left.
// Reset clears all channel state and loads the register defaults. A stall on
// the result side holds one finished beat plus one waiting command.
module pyro_channel_safety_controller (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] switch_closed, [12:1] sense_mv, [13] latch_already_fired,
    // [21:14] fire_reason, [23:22] zero
    input  logic [23:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [3:1] refusal, [4] gate, [5] is_armed, [6] has_fired,
    // [7] continuity_good, [23:8] match_mv, [39:24] fires_done,
    // [47:40] recorded_reason, [48] latch_write, [49] pulse_ended, [55:50] zero
    output logic [55:0] m_tdata,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    pcsc_pkg::cfg_t    cfg;
    pcsc_pkg::item_t   item_reg;
    pcsc_pkg::result_t result;
    pcsc_pkg::result_t result_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              s_accept;

    pcsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held command moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    pcsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.action              <= s_tuser;
            item_reg.switch_closed       <= s_tdata[0];
            item_reg.sense_mv            <= s_tdata[12:1];
            item_reg.latch_already_fired <= s_tdata[13];
            item_reg.fire_reason         <= s_tdata[21:14];
        end
        if (advance)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, result_reg};

endmodule
